>>> rtl/cemt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cemt_pkg: shared types and codes of the channel enable mask table
// Operation codes, mask control codes, transfer widths and the structs
// that pass between the sequencer, the table and the scan unit.
// ----------------------------------------------------------------------------
package cemt_pkg;

    // transfer widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;
    localparam int MODE_W    = 3;

    // operation codes carried in s_tuser
    localparam logic [MODE_W-1:0] MODE_WRITE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DISABLE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHECK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_APPLY    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FEASIBLE = 3'd4;

    // mask control codes
    localparam logic [2:0] CTL_DIRECT = 3'd0;
    localparam logic [2:0] CTL_ALL_ON = 3'd6;

    // one decoded operation as held by the sequencer
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [3:0]        channel;
        logic              freq_defined;
        logic [15:0]       rate_map_in;
        logic [2:0]        mask_control;
        logic [15:0]       chan_mask;
        logic [3:0]        data_rate;
    } cmd_t;

    // result of an operation before it enters the output register
    typedef struct packed {
        logic        flag;
        logic [15:0] enable_mask;
    } res_t;

    // status of the feasibility scan unit
    typedef struct packed {
        logic done;
        logic found;
    } scan_stat_t;

endpackage

>>> rtl/channel_enable_mask_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_enable_mask_table: radio channel table with enable mask
// Each item is held in the command register on acceptance; its result is
// loaded into the output register once that is free. The rate feasibility
// test first runs the scan unit, which tests one channel per cycle.
// A new item is taken only in the idle state, after the last result is loaded.
// Reset (aresetn low, synchronous) clears the table, the mask and all control.
// ----------------------------------------------------------------------------
module channel_enable_mask_table #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // channel[3:0], freq_defined[4], rate_map_in[20:5], mask_control[23:21],
    // chan_mask[39:24], data_rate[43:40], zero[47:44]
    input  logic [cemt_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[2:0]
    input  logic [cemt_pkg::MODE_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // flag[0], enable_mask[16:1], zero[23:17]
    output logic [cemt_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0]                     state_reg, state_next;
    cemt_pkg::cmd_t                 cmd_reg;
    logic                           m_tvalid_reg;
    logic [cemt_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           accept;
    logic                           out_free;
    logic                           commit;
    logic                           scan_start;
    logic                           res_flag;
    cemt_pkg::res_t                 tbl_res;
    cemt_pkg::scan_stat_t           scan_stat;
    logic [IDX_W-1:0]               scan_idx;
    logic [15:0]                    rate_word;
    logic                           en_bit;

    assign s_tready   = state_reg == ST_IDLE;
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign commit     = (state_reg == ST_EXEC) && out_free;
    assign scan_start = accept && (s_tuser == cemt_pkg::MODE_FEASIBLE);

    // hold the accepted item for the length of its work
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg.mode         <= s_tuser;
            cmd_reg.channel      <= s_tdata[3:0];
            cmd_reg.freq_defined <= s_tdata[4];
            cmd_reg.rate_map_in  <= s_tdata[20:5];
            cmd_reg.mask_control <= s_tdata[23:21];
            cmd_reg.chan_mask    <= s_tdata[39:24];
            cmd_reg.data_rate    <= s_tdata[43:40];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (scan_start) begin
                    state_next = ST_SCAN;
                end else if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_SCAN: begin
                if (scan_stat.done) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    cemt_table #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd_reg),
        .commit    (commit),
        .scan_idx  (scan_idx),
        .res       (tbl_res),
        .rate_word (rate_word),
        .en_bit    (en_bit)
    );

    cemt_scan #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (scan_start),
        .data_rate (cmd_reg.data_rate),
        .rate_word (rate_word),
        .en_bit    (en_bit),
        .idx       (scan_idx),
        .stat      (scan_stat)
    );

    assign res_flag = (cmd_reg.mode == cemt_pkg::MODE_FEASIBLE) ? scan_stat.found
                                                                : tbl_res.flag;

    // output register: load on commit, drop once the transfer is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_tdata_reg <= {7'd0, tbl_res.enable_mask, res_flag};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/cemt_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cemt_table: channel entry store and enable mask
// Holds the defined flags, rate maps and enable mask, works out the result
// of every non-scan operation and updates the store on commit. Offers one
// read port at the scan index for the feasibility unit.
// ----------------------------------------------------------------------------
module cemt_table #(
    parameter int NUM_CHANNELS = 16,
    parameter int IDX_W        = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cemt_pkg::cmd_t      cmd,
    input  logic                commit,
    input  logic [IDX_W-1:0]    scan_idx,
    output cemt_pkg::res_t      res,
    output logic [15:0]         rate_word,
    output logic                en_bit
);

    localparam logic [15:0] TABLE_MASK = 16'((32'd1 << NUM_CHANNELS) - 32'd1);

    logic [NUM_CHANNELS-1:0] def_reg;
    logic [15:0]             rmap_reg [NUM_CHANNELS];
    logic [15:0]             mask_reg;
    logic [15:0]             mask_next;
    logic [15:0]             def_set;
    logic                    in_table;
    logic [IDX_W-1:0]        wr_idx;
    logic                    flag;

    // widen the defined flags to a 16-bit channel set
    genvar gi;
    generate
        for (gi = 0; gi < 16; gi++) begin : g_defset
            if (gi < NUM_CHANNELS) begin : g_on
                assign def_set[gi] = def_reg[gi];
            end else begin : g_off
                assign def_set[gi] = 1'b0;
            end
        end
    endgenerate

    assign in_table = {1'b0, cmd.channel} < 5'(NUM_CHANNELS);
    assign wr_idx   = cmd.channel[IDX_W-1:0];

    // decode the operation into its flag and next enable mask
    always_comb begin
        flag      = 1'b0;
        mask_next = mask_reg;
        unique case (cmd.mode)
            cemt_pkg::MODE_WRITE: begin
                flag = in_table;
            end
            cemt_pkg::MODE_DISABLE: begin
                if (in_table) begin
                    mask_next = mask_reg & ~(16'd1 << cmd.channel);
                    flag      = mask_reg[cmd.channel];
                end
            end
            cemt_pkg::MODE_CHECK: begin
                if (cmd.mask_control == cemt_pkg::CTL_DIRECT) begin
                    flag = (cmd.chan_mask & ~def_set) == 16'd0;
                end else if (cmd.mask_control == cemt_pkg::CTL_ALL_ON) begin
                    flag = 1'b1;
                end
            end
            cemt_pkg::MODE_APPLY: begin
                if (cmd.mask_control == cemt_pkg::CTL_DIRECT) begin
                    mask_next = cmd.chan_mask & TABLE_MASK;
                end else if (cmd.mask_control == cemt_pkg::CTL_ALL_ON) begin
                    mask_next = def_set;
                end
                flag = mask_next != 16'd0;
            end
            default: begin
                flag = 1'b0;
            end
        endcase
    end

    assign res.flag        = flag;
    assign res.enable_mask = mask_next;

    // scan read port
    assign rate_word = rmap_reg[scan_idx];
    assign en_bit    = mask_reg[scan_idx];

    // update the store when the operation commits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_reg  <= '0;
            mask_reg <= 16'd0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                rmap_reg[i] <= 16'd0;
            end
        end else if (commit) begin
            mask_reg <= mask_next;
            if (in_table && cmd.mode == cemt_pkg::MODE_WRITE) begin
                def_reg[wr_idx]  <= cmd.freq_defined;
                rmap_reg[wr_idx] <= cmd.rate_map_in;
            end else if (in_table && cmd.mode == cemt_pkg::MODE_DISABLE) begin
                def_reg[wr_idx]  <= 1'b0;
                rmap_reg[wr_idx] <= 16'd0;
            end
        end
    end

endmodule

>>> rtl/cemt_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cemt_scan: feasibility scan unit
// Walks the channels one per cycle, testing the enable bit and the rate
// map bit of the requested data rate in one shared bit test.
// ----------------------------------------------------------------------------
module cemt_scan #(
    parameter int NUM_CHANNELS = 16,
    parameter int IDX_W        = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [3:0]            data_rate,
    input  logic [15:0]           rate_word,
    input  logic                  en_bit,
    output logic [IDX_W-1:0]      idx,
    output cemt_pkg::scan_stat_t  stat
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    logic             running_reg, running_next;
    logic             done_reg, done_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // advance the scan by one channel a cycle
    always_comb begin
        running_next = running_reg;
        done_next    = done_reg;
        found_next   = found_reg;
        idx_next     = idx_reg;
        if (start) begin
            running_next = 1'b1;
            done_next    = 1'b0;
            found_next   = 1'b0;
            idx_next     = '0;
        end else if (running_reg) begin
            found_next = found_reg | (en_bit & rate_word[data_rate]);
            if (idx_reg == LAST_IDX) begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
            idx_reg     <= '0;
        end else begin
            running_reg <= running_next;
            done_reg    <= done_next;
            found_reg   <= found_next;
            idx_reg     <= idx_next;
        end
    end

    assign idx        = idx_reg;
    assign stat.done  = done_reg;
    assign stat.found = found_reg;

endmodule

>>> rtl/cemt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cemt_checker: port checks for the channel enable mask table
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module cemt_checker #(
    parameter int NUM_CHANNELS = 16
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cemt_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam logic [15:0] TABLE_MASK = 16'((32'd1 << NUM_CHANNELS) - 32'd1);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time: no transfer in the cycle after one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // enable mask never names a channel beyond the table
    a_mask_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16:1] & ~TABLE_MASK) == 16'd0)
        else $error("enable mask beyond table");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:17] == 7'd0)
        else $error("result padding not zero");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind channel_enable_mask_table cemt_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_cemt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
